>>> sv/wrmt_pkg.sv
// Shared types, codes and widths of the wildcard rule match table.
`default_nettype none
package wrmt_pkg;

  // Fixed widths of the port fields
  localparam int IN_FACTORS = 4;
  localparam int IN_VAL_W   = 4;
  localparam int IN_ID_W    = 32;
  localparam int OUT_ID_W   = 32;
  localparam int CNT_OUT_W  = 7;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int VC_W       = 5;

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUST = 3'd4;

  // Strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic eval;         // capture compare flags and load the scan line
    logic erase_shift;  // close the gap left by an erased rule
    logic scan_shift;   // move the scan line one cell towards cell zero
  } wrmt_ctrl_t;

endpackage
`default_nettype wire

>>> sv/wrmt_cell.sv
// One table cell: a stored rule, its compare flags and one scan line stage.
`default_nettype none
module wrmt_cell
  import wrmt_pkg::*;
#(
  parameter int NUM_FACTORS = 4,
  parameter int VALUE_BITS  = 4,
  parameter int ID_BITS     = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wrmt_ctrl_t                         ctrl,
  input  wire                                wr_en,
  input  wire                                valid,
  input  wire  [NUM_FACTORS-1:0]             ins_given,
  input  wire  [NUM_FACTORS*VALUE_BITS-1:0]  ins_val,
  input  wire  [ID_BITS-1:0]                 ins_id,
  input  wire  [NUM_FACTORS-1:0]             q_mask,
  input  wire  [NUM_FACTORS*((VALUE_BITS > IN_VAL_W) ? VALUE_BITS : IN_VAL_W)-1:0] q_val,
  input  wire  [ID_BITS-1:0]                 target,
  input  wire  [NUM_FACTORS-1:0]             nbr_given,
  input  wire  [NUM_FACTORS*VALUE_BITS-1:0]  nbr_val,
  input  wire  [ID_BITS-1:0]                 nbr_id,
  input  wire                                nbr_scan_vld,
  input  wire  [ID_BITS-1:0]                 nbr_scan_id,
  output logic [NUM_FACTORS-1:0]             given,
  output logic [NUM_FACTORS*VALUE_BITS-1:0]  val,
  output logic [ID_BITS-1:0]                 id,
  output logic                               scan_vld,
  output logic [ID_BITS-1:0]                 scan_id,
  output logic                               hit
);

  localparam int CMP_W = (VALUE_BITS > IN_VAL_W) ? VALUE_BITS : IN_VAL_W;

  logic [NUM_FACTORS-1:0]            given_r;
  logic [NUM_FACTORS*VALUE_BITS-1:0] val_r;
  logic [ID_BITS-1:0]                id_r;
  logic                              hit_r;
  logic                              ge_r;
  logic                              scan_vld_r;
  logic [ID_BITS-1:0]                scan_id_r;
  logic                              match;

  // Match the query on every factor both sides specify
  always_comb begin
    match = valid;
    for (int k = 0; k < NUM_FACTORS; k++) begin
      if (q_mask[k] && given_r[k] &&
          (CMP_W'(val_r[k*VALUE_BITS +: VALUE_BITS]) != q_val[k*CMP_W +: CMP_W])) begin
        match = 1'b0;
      end
    end
  end

  // Hold the rule; load on insert, take the upper neighbour on erase
  always_ff @(posedge clk) begin
    if (wr_en) begin
      given_r <= ins_given;
      val_r   <= ins_val;
      id_r    <= ins_id;
    end else if (ctrl.erase_shift && ge_r) begin
      given_r <= nbr_given;
      val_r   <= nbr_val;
      id_r    <= nbr_id;
    end
  end

  // Capture compare flags; ids ascend along the row, so ge marks the cells to shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      ge_r       <= 1'b0;
      scan_vld_r <= 1'b0;
    end else if (ctrl.eval) begin
      hit_r      <= valid && (id_r == target);
      ge_r       <= valid && (id_r >= target);
      scan_vld_r <= match;
    end else if (ctrl.scan_shift) begin
      scan_vld_r <= nbr_scan_vld;
    end
  end

  // Scan line id stage
  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      scan_id_r <= id_r;
    end else if (ctrl.scan_shift) begin
      scan_id_r <= nbr_scan_id;
    end
  end

  assign given    = given_r;
  assign val      = val_r;
  assign id       = id_r;
  assign scan_vld = scan_vld_r;
  assign scan_id  = scan_id_r;
  assign hit      = hit_r;

endmodule
`default_nettype wire

>>> sv/wildcard_rule_match_table_unit.sv
// Top level of the wildcard rule match table: sequencer and row of cells.
//
//  channel  direction  handshake                     words
//  in_*     input      start & !busy                 command, mask, values, target id
//  cfg_*    input      cfg_valid & cfg_ready         register index, data
//  out_*    output     out_strobe, one cycle         status, rule id, count, last
//
// Insert and count answer with a single word. Erase: the cells register their
// id compares, then, if one holds the target, the rules above it shift down by one.
// A query: the cells register their compares and load the scan line, which then
// carries the matches down to cell zero, one result word per match, and stops
// after the last one. The receiver cannot stall. Reset clears the count and the
// id counter and sets the value counts to sixteen.
`default_nettype none
module wildcard_rule_match_table_unit
  import wrmt_pkg::*;
#(
  parameter int NUM_FACTORS = 4,
  parameter int VALUE_BITS  = 4,
  parameter int ENTRIES     = 64,
  parameter int ID_BITS     = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire  [CMD_W-1:0]     in_command,
  input  wire  [IN_FACTORS-1:0] in_given_mask,
  input  wire  [IN_VAL_W-1:0]  in_value_0,
  input  wire  [IN_VAL_W-1:0]  in_value_1,
  input  wire  [IN_VAL_W-1:0]  in_value_2,
  input  wire  [IN_VAL_W-1:0]  in_value_3,
  input  wire  [IN_ID_W-1:0]   in_target_id,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [VC_W-1:0]      cfg_data,
  output logic                 out_strobe,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_ID_W-1:0]  out_rule_id,
  output logic [CNT_OUT_W-1:0] out_stored_count,
  output logic                 out_last
);

  localparam int CMP_W    = (VALUE_BITS > IN_VAL_W) ? VALUE_BITS : IN_VAL_W;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int ID_EXT_W = (ID_BITS > IN_ID_W) ? ID_BITS : IN_ID_W;
  localparam int RV_W     = NUM_FACTORS * VALUE_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_ERASE = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [ID_BITS-1:0]    next_id_r, next_id_nxt;
  logic [VC_W-1:0]       vcnt_r [IN_FACTORS];

  logic [CMD_W-1:0]      cmd_r;
  logic [IN_FACTORS-1:0] mask_r;
  logic [IN_VAL_W-1:0]   val_r [IN_FACTORS];
  logic [ID_BITS-1:0]    target_r;
  logic [ID_EXT_W-1:0]   target_ext;

  logic                  strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [OUT_ID_W-1:0]   rid_r, rid_nxt;
  logic                  last_r, last_nxt;

  wrmt_ctrl_t            ctrl;
  logic                  ins_we;
  logic [NUM_FACTORS-1:0] ins_given;
  logic [RV_W-1:0]       ins_val;
  logic [NUM_FACTORS-1:0] ins_bad;
  logic [NUM_FACTORS-1:0] q_mask;
  logic [NUM_FACTORS*CMP_W-1:0] q_val;

  logic [ENTRIES-1:0]    wr_en;
  logic [ENTRIES-1:0]    cell_valid;
  logic [NUM_FACTORS-1:0] c_given [ENTRIES];
  logic [RV_W-1:0]       c_val [ENTRIES];
  logic [ID_BITS-1:0]    c_id [ENTRIES];
  logic [ENTRIES-1:0]    c_scan_vld;
  logic [ID_BITS-1:0]    c_scan_id [ENTRIES];
  logic [ENTRIES-1:0]    c_hit;

  logic [ID_EXT_W-1:0]   ins_id_ext;
  logic [ID_EXT_W-1:0]   scan_id_ext;
  logic [ID_EXT_W-1:0]   tgt_id_ext;
  logic                  scan_rest;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign target_ext = ID_EXT_W'(in_target_id);

  // Value count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < IN_FACTORS; k++) begin
        vcnt_r[k] <= VC_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      vcnt_r[cfg_index] <= cfg_data;
    end
  end

  // Capture the command word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r     <= in_command;
      mask_r    <= in_given_mask;
      val_r[0]  <= in_value_0;
      val_r[1]  <= in_value_1;
      val_r[2]  <= in_value_2;
      val_r[3]  <= in_value_3;
      target_r  <= target_ext[ID_BITS-1:0];
    end
  end

  // Per-factor insert data, range check and query key
  for (genvar k = 0; k < NUM_FACTORS; k++) begin : g_factor
    if (k < IN_FACTORS) begin : g_port
      logic [CMP_W-1:0] v_ext;
      assign v_ext = CMP_W'(val_r[k]);
      assign ins_given[k] = mask_r[k];
      assign ins_val[k*VALUE_BITS +: VALUE_BITS] =
        mask_r[k] ? v_ext[VALUE_BITS-1:0] : '0;
      assign ins_bad[k] = mask_r[k] &&
        (((v_ext >> VALUE_BITS) != '0) || ({1'b0, val_r[k]} >= vcnt_r[k]));
      assign q_mask[k] = mask_r[k];
      assign q_val[k*CMP_W +: CMP_W] = v_ext;
    end else begin : g_none
      assign ins_given[k] = 1'b0;
      assign ins_val[k*VALUE_BITS +: VALUE_BITS] = '0;
      assign ins_bad[k] = 1'b0;
      assign q_mask[k] = 1'b0;
      assign q_val[k*CMP_W +: CMP_W] = '0;
    end
  end

  assign ins_id_ext  = ID_EXT_W'(next_id_r);
  assign scan_id_ext = ID_EXT_W'(c_scan_id[0]);
  assign tgt_id_ext  = ID_EXT_W'(target_r);
  assign scan_rest   = |c_scan_vld[ENTRIES-1:1];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    next_id_nxt = next_id_r;
    strobe_nxt  = 1'b0;
    status_nxt  = ST_OK;
    rid_nxt     = '0;
    last_nxt    = 1'b1;
    ctrl        = '0;
    ins_we      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_INSERT: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            if (fill_r == CNT_W'(ENTRIES)) begin
              status_nxt = ST_FULL;
            end else if (|ins_bad) begin
              status_nxt = ST_RANGE;
            end else if (&next_id_r) begin
              status_nxt = ST_EXHAUST;
            end else begin
              ins_we      = 1'b1;
              fill_nxt    = fill_r + 1'b1;
              next_id_nxt = next_id_r + 1'b1;
              rid_nxt     = ins_id_ext[OUT_ID_W-1:0];
            end
          end
          CMD_ERASE: begin
            ctrl.eval = 1'b1;
            state_nxt = S_ERASE;
          end
          CMD_QUERY: begin
            ctrl.eval = 1'b1;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
          end
        endcase
      end
      S_ERASE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        if (|c_hit) begin
          ctrl.erase_shift = 1'b1;
          fill_nxt = fill_r - 1'b1;
          rid_nxt  = tgt_id_ext[OUT_ID_W-1:0];
        end else begin
          status_nxt = ST_MISS;
        end
      end
      S_SCAN: begin
        ctrl.scan_shift = 1'b1;
        if (c_scan_vld[0]) begin
          strobe_nxt = 1'b1;
          rid_nxt    = scan_id_ext[OUT_ID_W-1:0];
          last_nxt   = !scan_rest;
          if (!scan_rest) begin
            state_nxt = S_IDLE;
          end
        end else if (!scan_rest) begin
          // nothing matched at all
          strobe_nxt = 1'b1;
          status_nxt = ST_MISS;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      next_id_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      next_id_r <= next_id_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_rule_id      = rid_r;
  assign out_stored_count = CNT_OUT_W'(fill_r);
  assign out_last         = last_r;

  // Row of cells, each handing its contents to the cell below
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic [NUM_FACTORS-1:0] n_given;
    logic [RV_W-1:0]        n_val;
    logic [ID_BITS-1:0]     n_id;
    logic                   n_scan_vld;
    logic [ID_BITS-1:0]     n_scan_id;

    assign wr_en[j]      = ins_we && (fill_r == CNT_W'(j));
    assign cell_valid[j] = (CNT_W'(j) < fill_r);

    if (j < ENTRIES - 1) begin : g_mid
      assign n_given    = c_given[j+1];
      assign n_val      = c_val[j+1];
      assign n_id       = c_id[j+1];
      assign n_scan_vld = c_scan_vld[j+1];
      assign n_scan_id  = c_scan_id[j+1];
    end else begin : g_end
      assign n_given    = '0;
      assign n_val      = '0;
      assign n_id       = '0;
      assign n_scan_vld = 1'b0;
      assign n_scan_id  = '0;
    end

    wrmt_cell #(
      .NUM_FACTORS (NUM_FACTORS),
      .VALUE_BITS  (VALUE_BITS),
      .ID_BITS     (ID_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .wr_en        (wr_en[j]),
      .valid        (cell_valid[j]),
      .ins_given    (ins_given),
      .ins_val      (ins_val),
      .ins_id       (next_id_r),
      .q_mask       (q_mask),
      .q_val        (q_val),
      .target       (target_r),
      .nbr_given    (n_given),
      .nbr_val      (n_val),
      .nbr_id       (n_id),
      .nbr_scan_vld (n_scan_vld),
      .nbr_scan_id  (n_scan_id),
      .given        (c_given[j]),
      .val          (c_val[j]),
      .id           (c_id[j]),
      .scan_vld     (c_scan_vld[j]),
      .scan_id      (c_scan_id[j]),
      .hit          (c_hit[j])
    );
  end

`ifndef SYNTHESIS
  // A final word always leaves the block ready for the next command
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("final word emitted while still busy");

  // Rejections and misses are single words
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> out_last)
    else $error("non-ok status without last");

  // An accepted command occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // The count never passes the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond table depth");
`endif

endmodule
`default_nettype wire

>>> tb/wrmt_tb_pkg.sv
// Table predictor and result checker for the wildcard rule match table testbench.
`timescale 1ns / 100ps
package wrmt_tb_pkg;
  import wrmt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  // the all-ones id is never handed out
  localparam logic [OUT_ID_W-1:0] ID_SPENT = '1;

  typedef logic [IN_FACTORS-1:0][IN_VAL_W-1:0] factor_values_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_COUNT_0,
    REG_VALUE_COUNT_1,
    REG_VALUE_COUNT_2,
    REG_VALUE_COUNT_3
  } value_count_reg_e;

  typedef struct packed {
    logic [IN_FACTORS-1:0] given;
    factor_values_t        val;
    logic [OUT_ID_W-1:0]   id;
  } table_rule_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_ID_W-1:0]  rule_id;
    logic [CNT_OUT_W-1:0] stored_count;
    logic                 last;
  } table_word_t;

  class match_table_checker;
    table_rule_t         rules [TABLE_DEPTH];
    int                  fill;
    logic [OUT_ID_W-1:0] next_id;
    logic [VC_W-1:0]     value_count [IN_FACTORS];
    table_word_t         awaited_words [$];
    int unsigned         mismatches;

    function new();
      fill = 0;
      next_id = '0;
      mismatches = 0;
      foreach (value_count[k]) value_count[k] = VC_RESET;
    endfunction

    // Queue one awaited word; the count is the one after the command
    function void add_word(logic [STATUS_W-1:0] status, logic [OUT_ID_W-1:0] rule_id,
                           logic last);
      table_word_t w;
      w.status = status;
      w.rule_id = rule_id;
      w.stored_count = CNT_OUT_W'(fill);
      w.last = last;
      awaited_words = {awaited_words, w};
    endfunction

    // Advance the table by one accepted command and queue its words
    function void note_command(logic [CMD_W-1:0] cmd, logic [IN_FACTORS-1:0] mask,
                               factor_values_t vals, logic [IN_ID_W-1:0] target);
      table_rule_t         rule;
      logic [OUT_ID_W-1:0] hits [$];
      bit                  legal;
      bit                  hit;
      bit                  found;
      int                  pos;
      case (cmd)
        CMD_INSERT: begin
          legal = 1'b1;
          for (int k = 0; k < IN_FACTORS; k++)
            if (mask[k] && !(vals[k] < value_count[k])) legal = 1'b0;
          if (fill >= TABLE_DEPTH) begin
            add_word(ST_FULL, '0, 1'b1);
          end else if (!legal) begin
            add_word(ST_RANGE, '0, 1'b1);
          end else if (next_id == ID_SPENT) begin
            add_word(ST_EXHAUST, '0, 1'b1);
          end else begin
            rule.given = mask;
            rule.id = next_id;
            // wildcard factors hold zero, whatever was on the port
            for (int k = 0; k < IN_FACTORS; k++) rule.val[k] = mask[k] ? vals[k] : '0;
            rules[fill] = rule;
            fill++;
            next_id++;
            add_word(ST_OK, rule.id, 1'b1);
          end
        end
        CMD_ERASE: begin
          found = 1'b0;
          pos = 0;
          for (int i = 0; i < fill && !found; i++) begin
            if (rules[i].id == target) begin
              found = 1'b1;
              pos = i;
            end
          end
          if (found) begin
            // close the gap, keeping ascending id order
            for (int i = pos; i + 1 < fill; i++) rules[i] = rules[i + 1];
            fill--;
            add_word(ST_OK, target, 1'b1);
          end else begin
            add_word(ST_MISS, '0, 1'b1);
          end
        end
        CMD_QUERY: begin
          for (int i = 0; i < fill; i++) begin
            hit = 1'b1;
            for (int k = 0; k < IN_FACTORS; k++)
              if (mask[k] && rules[i].given[k] && rules[i].val[k] != vals[k]) hit = 1'b0;
            if (hit) hits = {hits, rules[i].id};
          end
          if (hits.size() == 0) add_word(ST_MISS, '0, 1'b1);
          foreach (hits[j]) add_word(ST_OK, hits[j], j == hits.size() - 1);
        end
        default: begin
          add_word(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    function void report(string field, logic [OUT_ID_W-1:0] want, logic [OUT_ID_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one word from the result port with the oldest awaited one
    function void check_result(logic [STATUS_W-1:0] status, logic [OUT_ID_W-1:0] rule_id,
                               logic [CNT_OUT_W-1:0] stored_count, logic last);
      table_word_t want;
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got status %0d id %0d count %0d last %0d",
                 $time, status, rule_id, stored_count, last);
      end else begin
        want = awaited_words.pop_front();
        if (status !== want.status)
          report("status", OUT_ID_W'(want.status), OUT_ID_W'(status));
        if (rule_id !== want.rule_id) report("rule_id", want.rule_id, rule_id);
        if (stored_count !== want.stored_count)
          report("stored_count", OUT_ID_W'(want.stored_count), OUT_ID_W'(stored_count));
        if (last !== want.last) report("last", OUT_ID_W'(want.last), OUT_ID_W'(last));
      end
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// Testbench top of the wildcard rule match table: clock, reset, stimulus and result check.
`timescale 1ns / 100ps
module tb;
  import wrmt_pkg::*;
  import wrmt_tb_pkg::*;

  localparam int     SETTLE_CYCLES = 8;
  localparam longint RUN_LIMIT_NS  = 2_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      in_command;
  logic [IN_FACTORS-1:0] in_given_mask;
  logic [IN_VAL_W-1:0]   in_value_0;
  logic [IN_VAL_W-1:0]   in_value_1;
  logic [IN_VAL_W-1:0]   in_value_2;
  logic [IN_VAL_W-1:0]   in_value_3;
  logic [IN_ID_W-1:0]    in_target_id;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [VC_W-1:0]       cfg_data;
  logic                  out_strobe;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_ID_W-1:0]   out_rule_id;
  logic [CNT_OUT_W-1:0]  out_stored_count;
  logic                  out_last;

  match_table_checker table_check;
  int                 no_idle_run;

  wildcard_rule_match_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_given_mask    (in_given_mask),
    .in_value_0       (in_value_0),
    .in_value_1       (in_value_1),
    .in_value_2       (in_value_2),
    .in_value_3       (in_value_3),
    .in_target_id     (in_target_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_rule_id      (out_rule_id),
    .out_stored_count (out_stored_count),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check every word on the result port at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      table_check.check_result(out_status, out_rule_id, out_stored_count, out_last);
  end

  // Mostly no gap, some short, a few long; now and then a run with no gaps at all
  function automatic int pick_gap();
    int roll;
    if (no_idle_run > 0) begin
      no_idle_run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) no_idle_run = $urandom_range(10, 30);
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold one command word until the block takes it, then idle for a random gap
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IN_FACTORS-1:0] mask,
                              input factor_values_t vals, input logic [IN_ID_W-1:0] target);
    int gap;
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_given_mask <= mask;
    in_value_0    <= vals[0];
    in_value_1    <= vals[1];
    in_value_2    <= vals[2];
    in_value_3    <= vals[3];
    in_target_id  <= target;
    do @(posedge clk); while (busy);
    table_check.note_command(cmd, mask, vals, target);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start, wait for every awaited word, then let the block settle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (table_check.awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold one register word until taken; valid is left high for the next one
  task automatic write_register(input value_count_reg_e reg_idx, input logic [VC_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    table_check.value_count[int'(reg_idx)] = data;
  endtask

  // Counts are packed factor 3 down to factor 0
  task automatic write_value_counts(input logic [IN_FACTORS-1:0][VC_W-1:0] counts);
    drain();
    write_register(REG_VALUE_COUNT_0, counts[0]);
    write_register(REG_VALUE_COUNT_1, counts[1]);
    write_register(REG_VALUE_COUNT_2, counts[2]);
    write_register(REG_VALUE_COUNT_3, counts[3]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one random command, biased towards legal values, stored ids and hits
  task automatic send_random_command(input int insert_pct, input int erase_pct,
                                     input int query_pct);
    int                    roll;
    int                    pick;
    int                    hi;
    logic [CMD_W-1:0]      cmd;
    logic [IN_FACTORS-1:0] mask;
    factor_values_t        vals;
    logic [IN_ID_W-1:0]    target;
    table_rule_t           rule;
    roll   = $urandom_range(0, 99);
    mask   = IN_FACTORS'($urandom_range(0, 15));
    vals   = (IN_FACTORS*IN_VAL_W)'($urandom);
    target = $urandom;
    if (roll < insert_pct) begin
      cmd = CMD_INSERT;
      for (int k = 0; k < IN_FACTORS; k++) begin
        if (table_check.value_count[k] != 0 && $urandom_range(0, 4) != 0) begin
          hi = table_check.value_count[k] > 16 ? 15 : table_check.value_count[k] - 1;
          vals[k] = IN_VAL_W'($urandom_range(0, hi));
        end
      end
    end else if (roll < insert_pct + erase_pct) begin
      cmd = CMD_ERASE;
      pick = $urandom_range(0, 9);
      if (table_check.fill > 0 && pick < 7)
        target = table_check.rules[$urandom_range(0, table_check.fill - 1)].id;
      else if (pick < 9)
        target = table_check.next_id - $urandom_range(1, 12);
    end else if (roll < insert_pct + erase_pct + query_pct) begin
      cmd = CMD_QUERY;
      // copy a stored rule's values so that most queries find something
      if (table_check.fill > 0 && $urandom_range(0, 3) != 0) begin
        rule = table_check.rules[$urandom_range(0, table_check.fill - 1)];
        for (int k = 0; k < IN_FACTORS; k++)
          if (rule.given[k]) vals[k] = rule.val[k];
      end
    end else begin
      cmd = CMD_COUNT;
    end
    send_command(cmd, mask, vals, target);
  endtask

  task automatic run_phase(input logic [IN_FACTORS-1:0][VC_W-1:0] counts, input int words,
                           input int insert_pct, input int erase_pct, input int query_pct);
    write_value_counts(counts);
    repeat (words) send_random_command(insert_pct, erase_pct, query_pct);
  endtask

  initial begin
    logic [IN_FACTORS-1:0][VC_W-1:0] mixed_counts;
    table_check   = new();
    no_idle_run   = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_COUNT;
    in_given_mask = '0;
    in_value_0    = '0;
    in_value_1    = '0;
    in_value_2    = '0;
    in_value_3    = '0;
    in_target_id  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_VALUE_COUNT_0;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: count, query everything, erase a missing id
    send_command(CMD_COUNT, 4'h0, 16'h0000, '0);
    send_command(CMD_QUERY, 4'h0, 16'h0000, '0);
    send_command(CMD_ERASE, 4'h0, 16'h0000, '0);
    // All wildcard, all lowest, all highest, partly specified (values factor 3 down to 0)
    send_command(CMD_INSERT, 4'h0, 16'hFFFF, '0);
    send_command(CMD_INSERT, 4'hF, 16'h0000, '0);
    send_command(CMD_INSERT, 4'hF, 16'hFFFF, '0);
    send_command(CMD_INSERT, 4'h5, 16'hF7F3, '0);
    send_command(CMD_QUERY, 4'h0, 16'h0000, '0);
    send_command(CMD_QUERY, 4'hF, 16'hFFFF, '0);
    send_command(CMD_QUERY, 4'h1, 16'h0003, '0);
    // Erase from the middle, again, a wide id, then the first
    send_command(CMD_ERASE, 4'h0, 16'h0000, 32'd1);
    send_command(CMD_ERASE, 4'h0, 16'h0000, 32'd1);
    send_command(CMD_ERASE, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_ERASE, 4'h0, 16'h0000, 32'd0);
    send_command(CMD_QUERY, 4'hF, 16'h4321, '0);
    send_command(CMD_COUNT, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);

    // Value count zero on factor 0, above sixteen on factor 1, one on factor 3
    write_value_counts({5'd1, 5'd16, 5'd31, 5'd0});
    send_command(CMD_INSERT, 4'h1, 16'h0000, '0);
    send_command(CMD_INSERT, 4'h2, 16'h00F0, '0);
    send_command(CMD_INSERT, 4'h8, 16'h1000, '0);
    send_command(CMD_INSERT, 4'hE, 16'h0F9F, '0);
    send_command(CMD_QUERY, 4'h1, 16'h0005, '0);
    send_command(CMD_QUERY, 4'hF, 16'h0F9F, '0);
    send_command(CMD_ERASE, 4'h0, 16'h0000, 32'd5);

    // Random phases: fill to full, narrow counts, erase-heavy, mixed counts, extreme counts
    run_phase({4{5'd16}}, 120, 80, 5, 10);
    run_phase({4{5'd1}}, 70, 30, 35, 25);
    run_phase({5'd5, 5'd16, 5'd9, 5'd2}, 90, 20, 45, 25);
    for (int k = 0; k < IN_FACTORS; k++) mixed_counts[k] = VC_W'($urandom_range(1, 16));
    run_phase(mixed_counts, 90, 45, 25, 20);
    run_phase({5'd31, 5'd0, 5'd16, 5'd16}, 90, 40, 25, 25);

    drain();
    if (table_check.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Abandon a run that hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> wildcard_rule_match_table_unit.f
sv/wrmt_pkg.sv
sv/wrmt_cell.sv
sv/wildcard_rule_match_table_unit.sv
tb/wrmt_tb_pkg.sv
tb/tb.sv
